>>> hw/rtl/ias_pkg.sv
// Shared types and constants for the IAS-style accumulator machine.
package ias_pkg;

  localparam int WORD_W     = 40;
  localparam int ADDR_W     = 12;
  localparam int OP_W       = 8;
  localparam int HALF_W     = 20;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 96;

  localparam logic [OP_W-1:0] OP_HALT       = 8'd0;
  localparam logic [OP_W-1:0] OP_LOAD       = 8'd1;
  localparam logic [OP_W-1:0] OP_LOAD_NEG   = 8'd2;
  localparam logic [OP_W-1:0] OP_LOAD_ABS   = 8'd3;
  localparam logic [OP_W-1:0] OP_LOAD_NABS  = 8'd4;
  localparam logic [OP_W-1:0] OP_ADD        = 8'd5;
  localparam logic [OP_W-1:0] OP_SUB        = 8'd6;
  localparam logic [OP_W-1:0] OP_ADD_ABS    = 8'd7;
  localparam logic [OP_W-1:0] OP_SUB_ABS    = 8'd8;
  localparam logic [OP_W-1:0] OP_LOAD_MQ    = 8'd9;
  localparam logic [OP_W-1:0] OP_AC_FROM_MQ = 8'd10;
  localparam logic [OP_W-1:0] OP_JUMP_LEFT  = 8'd13;
  localparam logic [OP_W-1:0] OP_JUMP_RIGHT = 8'd14;

  typedef struct packed {
    logic [WORD_W-1:0] acc;
    logic [WORD_W-1:0] mq;
    logic              halt;
    logic              jump;
    logic              right_only;
  } ias_exec_t;

endpackage

>>> hw/rtl/ias_ram.sv
// Generic single-port synchronous RAM with registered read.
module ias_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> hw/rtl/ias_exec.sv
// Instruction execute unit: one shared adder for loads, negation, abs and add/sub.
module ias_exec import ias_pkg::*; (
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [WORD_W-1:0] operand_i,
  input  logic [WORD_W-1:0] acc_i,
  input  logic [WORD_W-1:0] mq_i,
  output ias_exec_t         res_o
);

  logic              arith_en;
  logic              from_zero;
  logic              sub;
  logic              neg_m;
  logic [WORD_W-1:0] base;
  logic [WORD_W-1:0] sum;

  assign neg_m = operand_i[WORD_W-1];

  always_comb begin
    arith_en  = 1'b0;
    from_zero = 1'b0;
    sub       = 1'b0;
    case (opcode_i)
      OP_LOAD:      begin arith_en = 1'b1; from_zero = 1'b1; end
      OP_LOAD_NEG:  begin arith_en = 1'b1; from_zero = 1'b1; sub = 1'b1; end
      OP_LOAD_ABS:  begin arith_en = 1'b1; from_zero = 1'b1; sub = neg_m; end
      OP_LOAD_NABS: begin arith_en = 1'b1; from_zero = 1'b1; sub = ~neg_m; end
      OP_ADD:       begin arith_en = 1'b1; end
      OP_SUB:       begin arith_en = 1'b1; sub = 1'b1; end
      OP_ADD_ABS:   begin arith_en = 1'b1; sub = neg_m; end
      OP_SUB_ABS:   begin arith_en = 1'b1; sub = ~neg_m; end
      default:      begin arith_en = 1'b0; end
    endcase
  end

  assign base = from_zero ? '0 : acc_i;
  assign sum  = base + (sub ? ~operand_i : operand_i) + {{(WORD_W-1){1'b0}}, sub};

  always_comb begin
    res_o.acc        = arith_en ? sum : acc_i;
    res_o.mq         = mq_i;
    res_o.halt       = 1'b0;
    res_o.jump       = 1'b0;
    res_o.right_only = 1'b0;
    case (opcode_i)
      OP_HALT:       res_o.halt = 1'b1;
      OP_LOAD_MQ:    res_o.mq = operand_i;
      OP_AC_FROM_MQ: res_o.acc = mq_i;
      OP_JUMP_LEFT:  res_o.jump = 1'b1;
      OP_JUMP_RIGHT: begin
        res_o.jump       = 1'b1;
        res_o.right_only = 1'b1;
      end
      default:       res_o.halt = 1'b0;
    endcase
  end

endmodule

>>> hw/rtl/ias_accumulator_core_step.sv
// Top level of the IAS-style accumulator machine: sequencer, registers and output stage.
//
//   channel  dir  tdata (low bit up)                     tuser
//   s_axis   in   address[11:0] word[51:12]             action (0 write, 1 step)
//   m_axis   out  pc[11:0] acc[51:12] mq[91:52] halt[92]  -
//
// A write item goes from idle straight to done; a step item passes fetch and execute,
// with a second execute when both halves run, or goes to done once halted. Every fetch
// and operand read uses the word memory's single port, one registered read per cycle.
// Reset clears PC, AC, MQ and the flags; the word memory is not cleared.
// A result waits in the output register; the block stalls only if that register is full.
module ias_accumulator_core_step import ias_pkg::*; #(
  parameter int MEM_WORDS = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // address, word, zero fill
  input  logic                  s_axis_tuser,   // action
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // pc, acc, mq, halted, zero fill
);

  localparam int MEM_AW = $clog2(MEM_WORDS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [ADDR_W-1:0]     pc_q, pc_d;
  logic [WORD_W-1:0]     acc_q, acc_d;
  logic [WORD_W-1:0]     mq_q, mq_d;
  logic                  halt_q, halt_d;
  logic                  ro_q, ro_d;
  logic [WORD_W-1:0]     ir_q, ir_d;
  logic                  left_q, left_d;
  logic                  rd_zero_q;
  logic                  m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  logic                  in_accept;
  logic [ADDR_W-1:0]     in_addr;
  logic [WORD_W-1:0]     in_word;
  logic [ADDR_W-1:0]     mem_addr;
  logic                  mem_in_range;
  logic                  mem_we;
  logic [WORD_W-1:0]     ram_rdata;
  logic [WORD_W-1:0]     rd_word;
  logic [WORD_W-1:0]     w_eff;
  logic                  has_left;
  logic [OP_W-1:0]       ex_op;
  logic [ADDR_W-1:0]     ex_addr;
  ias_exec_t             ex_res;
  logic                  out_free;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_addr       = s_axis_tdata[ADDR_W-1:0];
  assign in_word       = s_axis_tdata[ADDR_W+WORD_W-1:ADDR_W];
  assign out_free      = !m_valid_q || m_axis_tready;

  assign rd_word  = rd_zero_q ? '0 : ram_rdata;
  assign w_eff    = {ro_q ? {HALF_W{1'b0}} : rd_word[WORD_W-1:HALF_W], rd_word[HALF_W-1:0]};
  assign has_left = |w_eff[WORD_W-1:HALF_W];
  assign ex_op    = left_q ? ir_q[WORD_W-1:WORD_W-OP_W] : ir_q[HALF_W-1:HALF_W-OP_W];
  assign ex_addr  = left_q ? ir_q[HALF_W+ADDR_W-1:HALF_W] : ir_q[ADDR_W-1:0];

  always_comb begin
    case (state_q)
      ST_IDLE:  mem_addr = s_axis_tuser ? pc_q : in_addr;
      ST_FETCH: mem_addr = has_left ? w_eff[HALF_W+ADDR_W-1:HALF_W] : w_eff[ADDR_W-1:0];
      default:  mem_addr = ir_q[ADDR_W-1:0];
    endcase
  end

  assign mem_in_range = ({1'b0, mem_addr} < (ADDR_W+1)'(MEM_WORDS));
  assign mem_we       = in_accept && !s_axis_tuser && mem_in_range;

  ias_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr[MEM_AW-1:0]),
    .wdata_i (in_word),
    .rdata_o (ram_rdata)
  );

  ias_exec u_exec (
    .opcode_i  (ex_op),
    .operand_i (rd_word),
    .acc_i     (acc_q),
    .mq_i      (mq_q),
    .res_o     (ex_res)
  );

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    acc_d   = acc_q;
    mq_d    = mq_q;
    halt_d  = halt_q;
    ro_d    = ro_q;
    ir_d    = ir_q;
    left_d  = left_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = (s_axis_tuser && !halt_q) ? ST_FETCH : ST_DONE;
        end
      end
      ST_FETCH: begin
        ir_d    = w_eff;
        left_d  = has_left;
        ro_d    = 1'b0;
        pc_d    = pc_q + 1'b1;
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        acc_d = ex_res.acc;
        mq_d  = ex_res.mq;
        if (ex_res.halt) begin
          halt_d = 1'b1;
        end
        if (ex_res.jump) begin
          pc_d = ex_addr;
          ro_d = ex_res.right_only;
        end
        if (left_q && !ex_res.halt && !ex_res.jump) begin
          left_d = 1'b0;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pc_q      <= '0;
      acc_q     <= '0;
      mq_q      <= '0;
      halt_q    <= 1'b0;
      ro_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      acc_q   <= acc_d;
      mq_q    <= mq_d;
      halt_q  <= halt_d;
      ro_q    <= ro_d;
      if (state_q == ST_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ir_q      <= ir_d;
    left_q    <= left_d;
    rd_zero_q <= !mem_in_range;
    if (state_q == ST_DONE && out_free) begin
      m_data_q <= {3'b000, halt_q, mq_q, acc_q, pc_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) !$fell(halt_q))
    else $error("halt flag cleared");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_IDLE))
    else $error("memory written outside idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FETCH) |-> ($past(state_q) == ST_IDLE))
    else $error("fetch entered without accepted item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_DONE) |=> $stable(pc_q))
    else $error("pc changed outside instruction execution");

endmodule
